FILE: rtl/core/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants of the sorted candidate pool core.
// ----------------------------------------------------------------------------
package scp_pkg;

    // Default sizing
    localparam int POOL_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF   = 24;

    // Fixed field widths of the channels
    localparam int OP_W     = 2;
    localparam int ID_W     = 24;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 6;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 7'd64;
    localparam logic [KEY_W-1:0] KEY_MAX       = '1;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_TAKE   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic clear;   // return slot to reset value
        logic take;    // take transaction in this cycle
        logic scan;    // compare step of the insert scan
        logic commit;  // place the candidate and shift the tail
    } cell_ctrl_t;

    // Compare report of the cell under scan
    typedef struct packed {
        logic gt;   // slot key greater than candidate key
        logic eq;   // slot key equal to candidate key
        logic dup;  // equal key and same id
    } cell_rpt_t;

endpackage

FILE: rtl/core/scp_ifs.sv
// ----------------------------------------------------------------------------
// scp channel interfaces
// Valid/ready channels for requests, results and the pool size register.
// ----------------------------------------------------------------------------
interface scp_req_if;
    import scp_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   item_id;
    logic [KEY_W-1:0]  item_distance;
    logic [POS_W-1:0]  take_index;

    modport source (output valid, op, item_id, item_distance, take_index, input ready);
    modport sink   (input valid, op, item_id, item_distance, take_index, output ready);
endinterface

interface scp_rsp_if;
    import scp_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  position;
    logic              accepted;
    logic [ID_W-1:0]   entry_id;
    logic [KEY_W-1:0]  entry_distance;
    logic              entry_unexpanded;

    modport source (output valid, position, accepted, entry_id, entry_distance,
                    entry_unexpanded, input ready);
    modport sink   (input valid, position, accepted, entry_id, entry_distance,
                    entry_unexpanded, output ready);
endinterface

interface scp_cfg_if;
    import scp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CFG_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/scp_cell.sv
// ----------------------------------------------------------------------------
// scp_cell
// One pool slot: compares against the broadcast candidate when scanned,
// loads from its left neighbor on a shift, answers take reads.
// ----------------------------------------------------------------------------
module scp_cell #(
    parameter int INDEX      = 0,
    parameter int POOL_DEPTH = scp_pkg::POOL_DEPTH_DEF,
    parameter int ID_WIDTH   = scp_pkg::ID_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  scp_pkg::cell_ctrl_t               ctrl,
    input  logic [$clog2(POOL_DEPTH)-1:0]     scan_idx,
    input  logic [$clog2(POOL_DEPTH)-1:0]     take_idx,
    input  logic [$clog2(POOL_DEPTH)-1:0]     place_pos,
    input  logic [$clog2(POOL_DEPTH+1)-1:0]   used,
    input  logic [ID_WIDTH-1:0]               cand_id,
    input  logic [scp_pkg::KEY_W-1:0]         cand_key,
    input  logic [ID_WIDTH-1:0]               left_id,
    input  logic [scp_pkg::KEY_W-1:0]         left_dist,
    input  logic                              left_flag,
    output logic [ID_WIDTH-1:0]               slot_id,
    output logic [scp_pkg::KEY_W-1:0]         slot_dist,
    output logic                              slot_flag,
    output scp_pkg::cell_rpt_t                rpt,
    output logic [scp_pkg::ID_W-1:0]          tk_id,
    output logic [scp_pkg::KEY_W-1:0]         tk_dist,
    output logic                              tk_flag
);
    import scp_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int UW = $clog2(POOL_DEPTH + 1);
    localparam logic [IW-1:0] MY_IDX  = IW'(INDEX);
    localparam logic [UW-1:0] MY_UIDX = UW'(INDEX);

    logic [ID_WIDTH-1:0] id_reg;
    logic [KEY_W-1:0]    dist_reg;
    logic                flag_reg;
    logic                scan_hit;
    logic                take_sel;

    // Compare and take select
    always_comb
    begin
        scan_hit = ctrl.scan && (scan_idx == MY_IDX);
        take_sel = ctrl.take && (take_idx == MY_IDX);
        rpt.gt   = scan_hit && (dist_reg > cand_key);
        rpt.eq   = scan_hit && (dist_reg == cand_key);
        rpt.dup  = rpt.eq && (id_reg == cand_id);
        tk_id    = take_sel ? ID_W'(id_reg) : '0;
        tk_dist  = take_sel ? dist_reg : '0;
        tk_flag  = take_sel && flag_reg;
    end

    // Slot storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg   <= '0;
            dist_reg <= KEY_MAX;
            flag_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            id_reg   <= '0;
            dist_reg <= KEY_MAX;
            flag_reg <= 1'b0;
        end
        else if (take_sel)
        begin
            flag_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            if (place_pos == MY_IDX)
            begin
                id_reg   <= cand_id;
                dist_reg <= cand_key;
                flag_reg <= 1'b1;
            end
            else if ((MY_IDX > place_pos) && (MY_UIDX < used))
            begin
                id_reg   <= left_id;
                dist_reg <= left_dist;
                flag_reg <= left_flag;
            end
        end
    end

    assign slot_id   = id_reg;
    assign slot_dist = dist_reg;
    assign slot_flag = flag_reg;

endmodule

FILE: rtl/core/sorted_candidate_pool_insert_core.sv
// ----------------------------------------------------------------------------
// sorted_candidate_pool_insert_core
// Insert: accept, then a scan of the slots in use from slot 0 (stops at slot 0
// when the candidate key is at or below the head), then commit once rsp is free.
// The scan token stepping through the cell chain sets the insert time.
// Take, clear and unused codes finish in the accept cycle (one per cycle, rsp free).
// Reset clears all slots in parallel (key max, id and flag zero); pool_size = 64.
// ----------------------------------------------------------------------------
module sorted_candidate_pool_insert_core #(
    parameter int POOL_DEPTH = scp_pkg::POOL_DEPTH_DEF,
    parameter int ID_WIDTH   = scp_pkg::ID_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    scp_req_if.sink   req,
    scp_rsp_if.source rsp,
    scp_cfg_if.sink   cfg
);
    import scp_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int UW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    pool_size_reg, pool_size_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       p_reg, p_next;
    logic [IW-1:0]       pfin_reg, pfin_next;
    logic                seen_reg, seen_next;
    logic                dup_reg, dup_next;
    logic                accept_reg, accept_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [KEY_W-1:0]    key_reg, key_next;

    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic                out_acc_reg, out_acc_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [KEY_W-1:0]    out_dist_reg, out_dist_next;
    logic                out_flag_reg, out_flag_next;

    logic [UW-1:0]       used;
    logic                out_free;
    logic                acc;
    logic                take_ok;
    logic                scan_last;
    cell_ctrl_t          ctrl;

    logic [ID_WIDTH-1:0] slot_id   [POOL_DEPTH];
    logic [KEY_W-1:0]    slot_dist [POOL_DEPTH];
    logic                slot_flag [POOL_DEPTH];
    cell_rpt_t           rpt       [POOL_DEPTH];
    logic [ID_W-1:0]     tk_id     [POOL_DEPTH];
    logic [KEY_W-1:0]    tk_dist   [POOL_DEPTH];
    logic                tk_flag   [POOL_DEPTH];

    cell_rpt_t           hit;
    logic [ID_W-1:0]     take_id;
    logic [KEY_W-1:0]    take_dist;
    logic                take_flag;

    // Handshakes and shared terms
    assign used      = (int'(pool_size_reg) > POOL_DEPTH) ? UW'(POOL_DEPTH)
                                                          : UW'(pool_size_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign cfg.ready = 1'b1;
    assign acc       = req.valid && req.ready;
    assign take_ok   = int'(req.take_index) < POOL_DEPTH;
    assign scan_last = UW'(cnt_reg) == (used - UW'(1));

    // Cell control broadcast
    always_comb
    begin
        ctrl.clear  = acc && (req.op == OP_CLEAR);
        ctrl.take   = acc && (req.op == OP_TAKE) && take_ok;
        ctrl.scan   = state_reg == ST_SCAN;
        ctrl.commit = (state_reg == ST_FIN) && out_free && accept_reg;
    end

    // Cell chain
    for (genvar i = 0; i < POOL_DEPTH; i++)
    begin : g_cell
        logic [ID_WIDTH-1:0] l_id;
        logic [KEY_W-1:0]    l_dist;
        logic                l_flag;

        if (i == 0)
        begin : g_head
            assign l_id   = '0;
            assign l_dist = KEY_MAX;
            assign l_flag = 1'b0;
        end
        else
        begin : g_body
            assign l_id   = slot_id[i-1];
            assign l_dist = slot_dist[i-1];
            assign l_flag = slot_flag[i-1];
        end

        scp_cell #(
            .INDEX      (i),
            .POOL_DEPTH (POOL_DEPTH),
            .ID_WIDTH   (ID_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .scan_idx  (cnt_reg),
            .take_idx  (IW'(req.take_index)),
            .place_pos (pfin_reg),
            .used      (used),
            .cand_id   (id_reg),
            .cand_key  (key_reg),
            .left_id   (l_id),
            .left_dist (l_dist),
            .left_flag (l_flag),
            .slot_id   (slot_id[i]),
            .slot_dist (slot_dist[i]),
            .slot_flag (slot_flag[i]),
            .rpt       (rpt[i]),
            .tk_id     (tk_id[i]),
            .tk_dist   (tk_dist[i]),
            .tk_flag   (tk_flag[i])
        );
    end

    // Gather reports; only one cell is scanned or selected at a time
    always_comb
    begin
        hit       = '0;
        take_id   = '0;
        take_dist = '0;
        take_flag = 1'b0;
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            hit       = hit | rpt[i];
            take_id   = take_id | tk_id[i];
            take_dist = take_dist | tk_dist[i];
            take_flag = take_flag | tk_flag[i];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        pool_size_next = pool_size_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        pfin_next      = pfin_reg;
        seen_next      = seen_reg;
        dup_next       = dup_reg;
        accept_next    = accept_reg;
        id_next        = id_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_pos_next   = out_pos_reg;
        out_acc_next   = out_acc_reg;
        out_id_next    = out_id_reg;
        out_dist_next  = out_dist_reg;
        out_flag_next  = out_flag_reg;

        if (cfg.valid)
        begin
            pool_size_next = cfg.data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    out_pos_next  = '0;
                    out_acc_next  = 1'b0;
                    out_id_next   = '0;
                    out_dist_next = '0;
                    out_flag_next = 1'b0;
                    case (req.op)
                        OP_INSERT:
                        begin
                            id_next  = ID_WIDTH'(req.item_id);
                            key_next = req.item_distance;
                            if (used == '0)
                            begin
                                // empty pool rejects at once
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                seen_next  = 1'b0;
                                dup_next   = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_TAKE:
                        begin
                            out_valid_next = 1'b1;
                            if (take_ok)
                            begin
                                out_pos_next  = req.take_index;
                                out_id_next   = take_id;
                                out_dist_next = take_dist;
                                out_flag_next = take_flag;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if ((cnt_reg == '0) && (hit.gt || hit.eq))
                begin
                    // candidate at or below the head goes first, no id check
                    accept_next = 1'b1;
                    pfin_next   = '0;
                    state_next  = ST_FIN;
                end
                else
                begin
                    if (!seen_reg && hit.gt)
                    begin
                        seen_next = 1'b1;
                        p_next    = cnt_reg;
                    end
                    if (!seen_reg && hit.dup)
                    begin
                        dup_next = 1'b1;
                    end
                    if (scan_last)
                    begin
                        // tail must exceed the key; duplicates only count before p
                        accept_next = hit.gt && !dup_reg;
                        pfin_next   = seen_reg ? p_reg : cnt_reg;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = accept_reg ? POS_W'(pfin_reg) : '0;
                    out_acc_next   = accept_reg;
                    out_id_next    = '0;
                    out_dist_next  = '0;
                    out_flag_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pool_size_reg <= POOL_SIZE_RST;
            cnt_reg       <= '0;
            p_reg         <= '0;
            pfin_reg      <= '0;
            seen_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            accept_reg    <= 1'b0;
            id_reg        <= '0;
            key_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_acc_reg   <= 1'b0;
            out_id_reg    <= '0;
            out_dist_reg  <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_size_reg <= pool_size_next;
            cnt_reg       <= cnt_next;
            p_reg         <= p_next;
            pfin_reg      <= pfin_next;
            seen_reg      <= seen_next;
            dup_reg       <= dup_next;
            accept_reg    <= accept_next;
            id_reg        <= id_next;
            key_reg       <= key_next;
            out_valid_reg <= out_valid_next;
            out_pos_reg   <= out_pos_next;
            out_acc_reg   <= out_acc_next;
            out_id_reg    <= out_id_next;
            out_dist_reg  <= out_dist_next;
            out_flag_reg  <= out_flag_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.position         = out_pos_reg;
    assign rsp.accepted         = out_acc_reg;
    assign rsp.entry_id         = out_id_reg;
    assign rsp.entry_distance   = out_dist_reg;
    assign rsp.entry_unexpanded = out_flag_reg;

    // Checks
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("request accepted while an insert is in flight");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (UW'(cnt_reg) < used))
        else $error("scan token beyond the slots in use");

    a_place_before_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && seen_reg) |-> (p_reg < cnt_reg))
        else $error("insert position not behind the scan token");

    a_commit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> (UW'(pfin_reg) < used))
        else $error("commit position outside the slots in use");

endmodule
